### hw/rtl/mpsd_pkg.sv
// ----------------------------------------------------------------------------
// mpsd_pkg
// Shared constants for the depth-first maze path search core: request codes,
// configuration register indexes, direction codes and fixed field widths.
// ----------------------------------------------------------------------------
package mpsd_pkg;

  // Defaults for the top-level parameters
  localparam int GRID_SIDE_DEF   = 8;
  localparam int STACK_DEPTH_DEF = 36;

  // Fixed field widths
  localparam int COORD_W    = 3;   // cell_row, cell_col, path_row, path_col
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  // Maze side limits and reset value
  localparam logic [CFG_DATA_W-1:0] SIDE_MIN   = 4'd3;
  localparam logic [CFG_DATA_W-1:0] SIDE_RESET = 4'd8;

  // Probe directions, tried in this order
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

endpackage

### hw/rtl/mpsd_ram.sv
// ----------------------------------------------------------------------------
// mpsd_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module mpsd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/maze_path_search_dfs_core.sv
// ----------------------------------------------------------------------------
// maze_path_search_dfs_core
// Depth-first maze path search. Load requests write one wall bit of the grid;
// a run request clears the visited marks, walks from cell (1,1) toward the
// exit cell (rows-2, cols-2) with an explicit backtrack stack, and streams
// the path cells out, exit cell last.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ---------------------------------------
//  request   start / busy              in_req_type, in_cell_row, in_cell_col,
//                                      in_wall
//  result    out_valid (one cycle)     out_path_row, out_path_col, out_found,
//                                      out_last
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  A load request writes its wall bit and leaves busy low.
//  A run request first sweeps the grid RAM to clear visited marks
//  (one entry per cycle), then probes: an off-grid or stack-full probe is
//  settled in S_PROBE, a probe through the grid RAM goes S_PROBE (read),
//  S_DECIDE (decide), and a backtrack pop adds S_RESTORE (restore from the
//  stack RAM read issued with the failed probe).
//  Each path result then goes S_EMIT_RD (stack RAM read), S_EMIT_OUT (drive),
//  the exit cell S_FINISH. A 3 x 3 maze skips the sweep and goes to S_FINISH.
//  Reset clears control state and the registers only; the receiver cannot
//  stall, so every result is driven for exactly one cycle.
// ----------------------------------------------------------------------------
module maze_path_search_dfs_core #(
  parameter int GRID_SIDE   = mpsd_pkg::GRID_SIDE_DEF,
  parameter int STACK_DEPTH = mpsd_pkg::STACK_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_req_type,
  input  logic [mpsd_pkg::COORD_W-1:0]     in_cell_row,
  input  logic [mpsd_pkg::COORD_W-1:0]     in_cell_col,
  input  logic                             in_wall,
  // result channel
  output logic                             out_valid,
  output logic [mpsd_pkg::COORD_W-1:0]     out_path_row,
  output logic [mpsd_pkg::COORD_W-1:0]     out_path_col,
  output logic                             out_found,
  output logic                             out_last,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mpsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpsd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Coordinate, address and stack widths
  localparam int CW         = $clog2(GRID_SIDE);
  localparam int RW         = CW + 1;
  localparam int NCELL      = GRID_SIDE * GRID_SIDE;
  localparam int AW         = $clog2(NCELL);
  localparam int CLW        = $clog2(NCELL + 1);
  localparam int SAW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int TW         = $clog2(STACK_DEPTH + 1);
  localparam int SEW        = 2 * CW + 2;
  localparam int START_ADDR = GRID_SIDE + 1;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b00000001,
    S_CLEAR    = 8'b00000010,
    S_PROBE    = 8'b00000100,
    S_DECIDE   = 8'b00001000,
    S_RESTORE  = 8'b00010000,
    S_EMIT_RD  = 8'b00100000,
    S_EMIT_OUT = 8'b01000000,
    S_FINISH   = 8'b10000000
  } state_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                              state_r, state_nxt;
  logic [mpsd_pkg::CFG_DATA_W-1:0]     rows_cfg_r, cols_cfg_r;
  logic [CW-1:0]                       cur_row_r, cur_row_nxt;
  logic [CW-1:0]                       cur_col_r, cur_col_nxt;
  logic [1:0]                          dir_r, dir_nxt;
  logic [TW-1:0]                       top_r, top_nxt;
  logic [TW-1:0]                       emit_r, emit_nxt;
  logic [CLW-1:0]                      clr_r, clr_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [mpsd_pkg::COORD_W-1:0]        out_row_r, out_col_r;
  logic                                out_found_r, out_found_nxt;
  logic                                out_last_r, out_last_nxt;

  // Grid RAM: bit 1 wall, bit 0 visited
  logic          g_we;
  logic [AW-1:0] g_wa, g_ra;
  logic [1:0]    g_wd, g_rd;

  // Stack RAM: {row, col, dir}
  logic           s_we;
  logic [SAW-1:0] s_wa, s_ra;
  logic [SEW-1:0] s_wd, s_rd;

  // --------------------------------------------------------------------------
  // Effective maze size and exit cell
  // --------------------------------------------------------------------------
  logic [RW-1:0] rows_eff, cols_eff;
  logic [CW-1:0] exit_row, exit_col;

  always_comb begin
    if (rows_cfg_r < mpsd_pkg::SIDE_MIN) begin
      rows_eff = RW'(mpsd_pkg::SIDE_MIN);
    end else if (32'(rows_cfg_r) > GRID_SIDE) begin
      rows_eff = RW'(GRID_SIDE);
    end else begin
      rows_eff = RW'(rows_cfg_r);
    end
    if (cols_cfg_r < mpsd_pkg::SIDE_MIN) begin
      cols_eff = RW'(mpsd_pkg::SIDE_MIN);
    end else if (32'(cols_cfg_r) > GRID_SIDE) begin
      cols_eff = RW'(GRID_SIDE);
    end else begin
      cols_eff = RW'(cols_cfg_r);
    end
  end

  assign exit_row = CW'(rows_eff - RW'(2));
  assign exit_col = CW'(cols_eff - RW'(2));

  // --------------------------------------------------------------------------
  // Neighbor of the current cell in the current direction. One extra bit
  // lets a step below zero wrap high, so a single compare catches both edges.
  // --------------------------------------------------------------------------
  logic [RW-1:0] nb_row, nb_col;
  logic [AW-1:0] nb_addr;
  logic          nb_in_grid, stack_room, nb_is_exit;

  always_comb begin
    nb_row = {1'b0, cur_row_r};
    nb_col = {1'b0, cur_col_r};
    unique case (dir_r)
      mpsd_pkg::DIR_RIGHT: nb_col = {1'b0, cur_col_r} + RW'(1);
      mpsd_pkg::DIR_DOWN:  nb_row = {1'b0, cur_row_r} + RW'(1);
      mpsd_pkg::DIR_LEFT:  nb_col = {1'b0, cur_col_r} - RW'(1);
      mpsd_pkg::DIR_UP:    nb_row = {1'b0, cur_row_r} - RW'(1);
      default:             nb_row = {1'b0, cur_row_r};
    endcase
  end

  assign nb_in_grid = (nb_row < rows_eff) && (nb_col < cols_eff);
  assign stack_room = (32'(top_r) + 1) < STACK_DEPTH;
  assign nb_addr    = AW'(32'(nb_row) * GRID_SIDE + 32'(nb_col));
  assign nb_is_exit = (nb_row == {1'b0, exit_row}) && (nb_col == {1'b0, exit_col});

  // Load address and range check
  logic          load_in_grid;
  logic [AW-1:0] load_addr;

  assign load_in_grid = (32'(in_cell_row) < GRID_SIDE) && (32'(in_cell_col) < GRID_SIDE);
  assign load_addr    = AW'(32'(in_cell_row) * GRID_SIDE + 32'(in_cell_col));

  // Result coordinates before cutting to the output width
  logic [CW-1:0]                  res_row, res_col;
  logic [CW+mpsd_pkg::COORD_W-1:0] res_row_ext, res_col_ext;

  assign res_row_ext = {{mpsd_pkg::COORD_W{1'b0}}, res_row};
  assign res_col_ext = {{mpsd_pkg::COORD_W{1'b0}}, res_col};

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    dir_nxt       = dir_r;
    top_nxt       = top_r;
    emit_nxt      = emit_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    res_row       = '0;
    res_col       = '0;
    g_we          = 1'b0;
    g_wa          = '0;
    g_wd          = '0;
    g_ra          = '0;
    s_we          = 1'b0;
    s_wa          = '0;
    s_wd          = '0;
    s_ra          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_req_type == mpsd_pkg::REQ_LOAD) begin
            // write the wall bit straight through; visited is swept per run
            g_we = load_in_grid;
            g_wa = load_addr;
            g_wd = {in_wall, 1'b0};
          end else begin
            cur_row_nxt = CW'(1);
            cur_col_nxt = CW'(1);
            dir_nxt     = mpsd_pkg::DIR_RIGHT;
            top_nxt     = '0;
            clr_nxt     = '0;
            if (exit_row == CW'(1) && exit_col == CW'(1)) begin
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_CLEAR;
            end
          end
        end
      end

      S_CLEAR: begin
        // read entry k while writing back entry k-1 with visited dropped,
        // except the start cell, which comes back marked
        if (32'(clr_r) < NCELL) begin
          g_ra = AW'(clr_r);
        end
        if (clr_r != '0) begin
          g_we = 1'b1;
          g_wa = AW'(clr_r - CLW'(1));
          g_wd = {g_rd[1], (AW'(clr_r - CLW'(1)) == AW'(START_ADDR))};
        end
        clr_nxt = clr_r + CLW'(1);
        if (32'(clr_r) == NCELL) begin
          state_nxt = S_PROBE;
        end
      end

      S_PROBE, S_DECIDE: begin
        if (state_r == S_PROBE && nb_in_grid && stack_room) begin
          g_ra      = nb_addr;
          state_nxt = S_DECIDE;
        end else if (state_r == S_DECIDE && !g_rd[1] && !g_rd[0]) begin
          // step in: mark visited, push the cell we leave
          g_we        = 1'b1;
          g_wa        = nb_addr;
          g_wd        = 2'b01;
          s_we        = 1'b1;
          s_wa        = SAW'(top_r);
          s_wd        = {cur_row_r, cur_col_r, dir_r};
          top_nxt     = top_r + TW'(1);
          cur_row_nxt = CW'(nb_row);
          cur_col_nxt = CW'(nb_col);
          dir_nxt     = mpsd_pkg::DIR_RIGHT;
          if (nb_is_exit) begin
            emit_nxt  = '0;
            state_nxt = S_EMIT_RD;
          end else begin
            state_nxt = S_PROBE;
          end
        end else if (dir_r != mpsd_pkg::DIR_UP) begin
          // blocked: advance to the next direction
          dir_nxt   = dir_r + 2'd1;
          state_nxt = S_PROBE;
        end else if (top_r != '0) begin
          // exhausted: pop and re-probe from the saved direction
          top_nxt   = top_r - TW'(1);
          s_ra      = SAW'(top_r - TW'(1));
          state_nxt = S_RESTORE;
        end else begin
          // stack empty: no path
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_RESTORE: begin
        cur_row_nxt = s_rd[SEW-1 -: CW];
        cur_col_nxt = s_rd[CW+1 -: CW];
        dir_nxt     = s_rd[1:0];
        state_nxt   = S_PROBE;
      end

      S_EMIT_RD: begin
        s_ra      = SAW'(emit_r);
        state_nxt = S_EMIT_OUT;
      end

      S_EMIT_OUT: begin
        res_row       = s_rd[SEW-1 -: CW];
        res_col       = s_rd[CW+1 -: CW];
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b1;
        emit_nxt      = emit_r + TW'(1);
        if (TW'(emit_r + TW'(1)) == top_r) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end

      S_FINISH: begin
        res_row       = exit_row;
        res_col       = exit_col;
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_cfg_r  <= mpsd_pkg::SIDE_RESET;
      cols_cfg_r  <= mpsd_pkg::SIDE_RESET;
      cur_row_r   <= CW'(1);
      cur_col_r   <= CW'(1);
      dir_r       <= mpsd_pkg::DIR_RIGHT;
      top_r       <= '0;
      emit_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      dir_r       <= dir_nxt;
      top_r       <= top_nxt;
      emit_r      <= emit_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mpsd_pkg::REG_ROWS: rows_cfg_r <= cfg_data;
          mpsd_pkg::REG_COLS: cols_cfg_r <= cfg_data;
          default:            rows_cfg_r <= rows_cfg_r;
        endcase
      end
    end
  end

  // Result payload: no reset needed, qualified by out_valid
  always_ff @(posedge clk) begin
    out_row_r   <= res_row_ext[mpsd_pkg::COORD_W-1:0];
    out_col_r   <= res_col_ext[mpsd_pkg::COORD_W-1:0];
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  mpsd_ram #(
    .WIDTH (2),
    .DEPTH (NCELL),
    .ADDR_W(AW)
  ) u_grid_ram (
    .clk  (clk),
    .we   (g_we),
    .waddr(g_wa),
    .wdata(g_wd),
    .raddr(g_ra),
    .rdata(g_rd)
  );

  mpsd_ram #(
    .WIDTH (SEW),
    .DEPTH (STACK_DEPTH),
    .ADDR_W(SAW)
  ) u_stack_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_wa),
    .wdata(s_wd),
    .raddr(s_ra),
    .rdata(s_rd)
  );

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign busy         = (state_r != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_path_row = out_row_r;
  assign out_path_col = out_col_r;
  assign out_found    = out_found_r;
  assign out_last     = out_last_r;

endmodule

### hw/rtl/mpsd_checker.sv
// ----------------------------------------------------------------------------
// mpsd_checker
// Port-level checks on the maze path search core, bound to the top level.
// ----------------------------------------------------------------------------
module mpsd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         in_req_type,
  input logic                         out_valid,
  input logic [mpsd_pkg::COORD_W-1:0] out_path_row,
  input logic [mpsd_pkg::COORD_W-1:0] out_path_col,
  input logic                         out_found,
  input logic                         out_last
);

  // results come only out of a run in progress
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a run in progress");

  // a no-path result is a single, final (0,0) result
  a_no_path_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |->
      out_last && out_path_row == '0 && out_path_col == '0)
    else $error("no-path result malformed");

  // the final result closes the run
  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result after the final one");

  // a load request does not leave the core busy
  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == mpsd_pkg::REQ_LOAD |=> !busy)
    else $error("load request left the core busy");

endmodule

bind maze_path_search_dfs_core mpsd_checker u_mpsd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_req_type (in_req_type),
  .out_valid   (out_valid),
  .out_path_row(out_path_row),
  .out_path_col(out_path_col),
  .out_found   (out_found),
  .out_last    (out_last)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the depth-first maze path search core. A queue of
// load and run requests feeds a clocked driver; an in-bench search over a
// mirror of the wall grid predicts every path cell, and a clocked monitor
// compares each result strobe with the oldest predicted cell.
// ----------------------------------------------------------------------------
module tb;

  localparam int     SIDE        = mpsd_pkg::GRID_SIDE_DEF;
  localparam int     DEPTH       = mpsd_pkg::STACK_DEPTH_DEF;
  localparam int     CW          = mpsd_pkg::COORD_W;
  localparam int     IW          = mpsd_pkg::CFG_IDX_W;
  localparam int     DW          = mpsd_pkg::CFG_DATA_W;
  localparam int     SETTLE      = 4;          // margin for a trailing load to finish in the core
  localparam int     TAIL        = 40;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic          req_type;
    logic [CW-1:0] row;
    logic [CW-1:0] col;
    logic          wall;
  } maze_req_t;

  typedef struct packed {
    logic [CW-1:0] row;
    logic [CW-1:0] col;
    logic          found;
    logic          last;
  } path_cell_t;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          start     = 1'b0;
  logic          busy;
  logic          in_req_type;
  logic [CW-1:0] in_cell_row;
  logic [CW-1:0] in_cell_col;
  logic          in_wall;
  logic          out_valid;
  logic [CW-1:0] out_path_row;
  logic [CW-1:0] out_path_col;
  logic          out_found;
  logic          out_last;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_data  = '0;

  maze_req_t  req_now = '0;      // request currently on the input ports
  maze_req_t  pending_reqs[$];   // requests not yet handed to the driver
  path_cell_t path_due[$];       // predicted path cells, oldest first

  // Mirror of the core: wall grid and size registers
  bit            maze_wall[SIDE*SIDE];
  logic [DW-1:0] rows_cfg = mpsd_pkg::SIDE_RESET;
  logic [DW-1:0] cols_cfg = mpsd_pkg::SIDE_RESET;

  int     gap_left    = 0;
  int     calm_left   = 0;
  int     mismatches  = 0;
  longint cycle_count = 0;

  assign in_req_type = req_now.req_type;
  assign in_cell_row = req_now.row;
  assign in_cell_col = req_now.col;
  assign in_wall     = req_now.wall;

  maze_path_search_dfs_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_cell_row  (in_cell_row),
    .in_cell_col  (in_cell_col),
    .in_wall      (in_wall),
    .out_valid    (out_valid),
    .out_path_row (out_path_row),
    .out_path_col (out_path_col),
    .out_found    (out_found),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Sizes below the minimum act as the minimum, above the grid as the grid.
  function automatic int clamp_side(input logic [DW-1:0] v);
    if (v < mpsd_pkg::SIDE_MIN) return int'(mpsd_pkg::SIDE_MIN);
    if (int'(v) > SIDE) return SIDE;
    return int'(v);
  endfunction

  // Apply one accepted request to the mirror. A load writes one wall bit; a
  // run searches depth first from (1,1) and queues the path it would stream.
  function automatic void predict_request(input maze_req_t rq);
    int         rows, cols, exit_r, exit_c;
    int         r, c, g, h, top, k;
    int         st_row[DEPTH];
    int         st_col[DEPTH];
    int         st_dir[DEPTH];
    bit         seen[SIDE*SIDE];
    bit         open_cell, done, reached;
    logic [1:0] d;
    path_cell_t due;

    if (rq.req_type == mpsd_pkg::REQ_LOAD) begin
      maze_wall[rq.row * SIDE + rq.col] = rq.wall;
      return;
    end

    rows   = clamp_side(rows_cfg);
    cols   = clamp_side(cols_cfg);
    exit_r = rows - 2;
    exit_c = cols - 2;

    // Smallest maze: the start cell already is the exit
    if (exit_r == 1 && exit_c == 1) begin
      due = '{row: CW'(1), col: CW'(1), found: 1'b1, last: 1'b1};
      path_due.push_back(due);
      return;
    end

    foreach (seen[i]) seen[i] = 1'b0;
    seen[1 * SIDE + 1] = 1'b1;
    r = 1;
    c = 1;
    d = mpsd_pkg::DIR_RIGHT;
    top = 0;
    done = 1'b0;
    reached = 1'b0;

    while (!done) begin
      g = r;
      h = c;
      case (d)
        mpsd_pkg::DIR_RIGHT: h = c + 1;
        mpsd_pkg::DIR_DOWN:  g = r + 1;
        mpsd_pkg::DIR_LEFT:  h = c - 1;
        default:             g = r - 1;
      endcase
      // Off-grid probes and a step that would fill the stack count as walls
      open_cell = 1'b0;
      if (g >= 0 && g < rows && h >= 0 && h < cols && top + 1 < DEPTH)
        open_cell = !maze_wall[g * SIDE + h] && !seen[g * SIDE + h];
      if (open_cell) begin
        seen[g * SIDE + h] = 1'b1;
        st_row[top] = r;
        st_col[top] = c;
        st_dir[top] = int'(d);
        top++;
        r = g;
        c = h;
        d = mpsd_pkg::DIR_RIGHT;
        if (g == exit_r && h == exit_c) begin
          reached = 1'b1;
          done = 1'b1;
        end
      end else if (d != mpsd_pkg::DIR_UP) begin
        d = d + 2'd1;
      end else if (top > 0) begin
        // Back up and retry from the direction that led here
        top--;
        r = st_row[top];
        c = st_col[top];
        d = 2'(st_dir[top]);
      end else begin
        done = 1'b1;
      end
    end

    if (!reached) begin
      due = '{row: '0, col: '0, found: 1'b0, last: 1'b1};
      path_due.push_back(due);
      return;
    end
    for (k = 0; k < top; k++) begin
      due = '{row: CW'(st_row[k]), col: CW'(st_col[k]), found: 1'b1, last: 1'b0};
      path_due.push_back(due);
    end
    due = '{row: CW'(exit_r), col: CW'(exit_c), found: 1'b1, last: 1'b1};
    path_due.push_back(due);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: predict on acceptance, hold while busy, then wait out the
  // drawn gap before presenting the next request. Runs of zero-gap requests
  // come in calm stretches so back-to-back traffic is covered too.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    maze_req_t nxt;
    int        gap;
    if (rst_n) begin
      if (start && !busy)
        predict_request(req_now);
      if (start && busy) begin
        // hold the request until the core takes it
      end else if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        req_now <= nxt;
        start   <= 1'b1;
        if (calm_left != 0) begin
          gap = 0;
          calm_left <= calm_left - 1;
        end else if ($urandom_range(0, 15) == 0) begin
          gap = 0;
          calm_left <= $urandom_range(8, 24);
        end else begin
          gap = $urandom_range(0, 9);
        end
        gap_left <= gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: every strobe must match the oldest predicted cell.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    path_cell_t want;
    if (rst_n && out_valid) begin
      if (path_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: row %0d col %0d found %0b last %0b",
                   out_path_row, out_path_col, out_found, out_last);
        mismatches++;
      end else begin
        want = path_due.pop_front();
        if (out_path_row !== want.row || out_path_col !== want.col ||
            out_found !== want.found || out_last !== want.last) begin
          if (mismatches < 10)
            $display({"result mismatch: want row %0d col %0d found %0b last %0b,",
                      " got row %0d col %0d found %0b last %0b"},
                     want.row, want.col, want.found, want.last,
                     out_path_row, out_path_col, out_found, out_last);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_req(input logic kind, input int r, input int c, input logic w);
    maze_req_t rq;
    rq.req_type = kind;
    rq.row      = CW'(r);
    rq.col      = CW'(c);
    rq.wall     = w;
    pending_reqs.push_back(rq);
  endtask

  // Wait until every request is taken and every path cell has come out, then
  // let a trailing load finish in the core.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || start || busy || path_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input int val);
    wait_idle();
    cfg_index <= idx;
    cfg_data  <= DW'(val);
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == mpsd_pkg::REG_ROWS) rows_cfg = DW'(val);
    else cols_cfg = DW'(val);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int rows_v, cols_v, rows_n, cols_n, density, random_reqs, loads;
    bit walled_border, is_border;
    logic w;

    // Write every wall bit first so no search ever reads an unwritten cell.
    // The layout (all open, row 4 walled except column 0) forces a long
    // serpentine so the first run fills the backtrack stack.
    for (int r = 0; r < SIDE; r++)
      for (int c = 0; c < SIDE; c++)
        add_req(mpsd_pkg::REQ_LOAD, r, c, r == 4 && c != 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full stack, start walled right and below, walled exit
    add_req(mpsd_pkg::REQ_RUN, 0, 0, 1'b0);
    add_req(mpsd_pkg::REQ_LOAD, 1, 2, 1'b1);
    add_req(mpsd_pkg::REQ_LOAD, 2, 1, 1'b1);
    add_req(mpsd_pkg::REQ_RUN, 7, 7, 1'b1);    // load fields on a run are ignored
    add_req(mpsd_pkg::REQ_LOAD, 1, 2, 1'b0);
    add_req(mpsd_pkg::REQ_LOAD, 2, 1, 1'b0);
    add_req(mpsd_pkg::REQ_LOAD, 6, 6, 1'b1);
    add_req(mpsd_pkg::REQ_RUN, 0, 0, 1'b0);
    add_req(mpsd_pkg::REQ_LOAD, 6, 6, 1'b0);

    // Smallest maze: start cell is the exit
    write_reg(mpsd_pkg::REG_ROWS, int'(mpsd_pkg::SIDE_MIN));
    write_reg(mpsd_pkg::REG_COLS, int'(mpsd_pkg::SIDE_MIN));
    add_req(mpsd_pkg::REQ_RUN, 0, 0, 1'b0);

    // Out-of-range sizes clamp to the limits
    write_reg(mpsd_pkg::REG_ROWS, 0);
    write_reg(mpsd_pkg::REG_COLS, 15);
    add_req(mpsd_pkg::REQ_RUN, 0, 0, 1'b0);
    write_reg(mpsd_pkg::REG_ROWS, 15);
    write_reg(mpsd_pkg::REG_COLS, 0);
    add_req(mpsd_pkg::REQ_RUN, 0, 0, 1'b0);

    // Odd size, two runs back to back
    write_reg(mpsd_pkg::REG_ROWS, 4);
    write_reg(mpsd_pkg::REG_COLS, 5);
    add_req(mpsd_pkg::REQ_RUN, 0, 0, 1'b0);
    add_req(mpsd_pkg::REQ_RUN, 0, 0, 1'b0);

    write_reg(mpsd_pkg::REG_ROWS, int'(mpsd_pkg::SIDE_RESET));
    write_reg(mpsd_pkg::REG_COLS, int'(mpsd_pkg::SIDE_RESET));
    add_req(mpsd_pkg::REQ_LOAD, 0, 0, 1'b1);
    add_req(mpsd_pkg::REQ_LOAD, 7, 7, 1'b1);
    add_req(mpsd_pkg::REQ_RUN, 0, 0, 1'b0);

    // Random phases: new sizes (drained first), often a fresh maze of the
    // size in use, then episodes of a few wall edits followed by a run.
    random_reqs = 0;
    while (random_reqs < 200) begin
      rows_v = ($urandom_range(0, 9) < 7) ? $urandom_range(mpsd_pkg::SIDE_MIN, SIDE)
                                          : $urandom_range(0, 15);
      cols_v = ($urandom_range(0, 9) < 7) ? $urandom_range(mpsd_pkg::SIDE_MIN, SIDE)
                                          : $urandom_range(0, 15);
      write_reg(mpsd_pkg::REG_ROWS, rows_v);
      write_reg(mpsd_pkg::REG_COLS, cols_v);
      rows_n  = clamp_side(DW'(rows_v));
      cols_n  = clamp_side(DW'(cols_v));
      density = $urandom_range(5, 45);

      if (rows_n * cols_n <= 30 || $urandom_range(0, 3) == 0) begin
        walled_border = 1'($urandom_range(0, 1));
        for (int r = 0; r < rows_n; r++)
          for (int c = 0; c < cols_n; c++) begin
            is_border = (r == 0 || c == 0 || r == rows_n - 1 || c == cols_n - 1);
            w = (walled_border && is_border) || ($urandom_range(0, 99) < density);
            // keep start and exit open so most fresh mazes are solvable
            if ((r == 1 && c == 1) || (r == rows_n - 2 && c == cols_n - 2)) w = 1'b0;
            add_req(mpsd_pkg::REQ_LOAD, r, c, w);
          end
        random_reqs += rows_n * cols_n;
      end

      repeat ($urandom_range(3, 8)) begin
        loads = $urandom_range(0, 4);
        repeat (loads) begin
          if ($urandom_range(0, 4) == 0)
            add_req(mpsd_pkg::REQ_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
                    1'($urandom_range(0, 1)));
          else
            add_req(mpsd_pkg::REQ_LOAD, $urandom_range(0, rows_n - 1),
                    $urandom_range(0, cols_n - 1), $urandom_range(0, 99) < density);
        end
        add_req(mpsd_pkg::REQ_RUN, $urandom_range(0, 7), $urandom_range(0, 7),
                1'($urandom_range(0, 1)));
        random_reqs += loads + 1;
      end
    end

    wait_idle();
    repeat (TAIL) @(posedge clk);
    if (path_due.size() != 0)
      $display("%0d predicted path cells never arrived", path_due.size());
    mismatches += path_due.size();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
